// File: rtl/urtm_pkg.sv
// ----------------------------------------------------------------------------
// Usage rule traffic metering package
// Shared widths, operation codes, the per-rule entry layout and time constants.
// ----------------------------------------------------------------------------
package urtm_pkg;

  // Default number of usage rule entries in the table.
  localparam int unsigned RuleEntriesDefault = 16;

  // Field widths.
  localparam int unsigned KindW    = 2;
  localparam int unsigned UrrIdW   = 4;
  localparam int unsigned OctetsW  = 16;
  localparam int unsigned TimeW    = 63;
  localparam int unsigned ThreshW  = 32;
  localparam int unsigned CountW   = 64;
  localparam int unsigned SeqW     = 32;
  localparam int unsigned DurW     = 44;

  // Duration divider: the dividend is a 64-bit word.
  localparam int unsigned DvdW     = 64;

  localparam logic [DvdW-1:0]  UsecPerSec = DvdW'(1000000);
  localparam logic [DvdW-1:0]  HalfSecUs  = UsecPerSec / 2;

  // One second is 2^6 * 15625 microseconds. The divider drops the power of
  // two with a shift, then divides by 15625 one 16-bit digit at a time. Each
  // digit step divides a 30-bit partial value by reciprocal multiplication:
  // the 31-bit reciprocal rounded up with a 44-bit shift is exact over that
  // range.
  localparam int unsigned PreShift = 6;
  localparam int unsigned DigitW   = 16;
  localparam int unsigned RcpDivW  = 14;
  localparam int unsigned RcpMulW  = 31;
  localparam int unsigned RcpShift = 44;

  localparam logic [RcpDivW-1:0] RcpDiv = RcpDivW'(15625);
  localparam logic [RcpMulW-1:0] RcpMul =
    RcpMulW'(((64'd1 << RcpShift) + 64'(RcpDiv) - 64'd1) / 64'(RcpDiv));

  // Operation carried by one input word.
  typedef enum logic [KindW-1:0] {
    KindCount    = 2'd0,
    KindReport   = 2'd1,
    KindSnapshot = 2'd2,
    KindStart    = 2'd3
  } kind_e;

  // One usage rule entry as held in the table memory.
  typedef struct packed {
    logic [CountW-1:0] octets_all;
    logic [CountW-1:0] octets_up;
    logic [CountW-1:0] octets_down;
    logic [CountW-1:0] packets_all;
    logic [CountW-1:0] packets_up;
    logic [CountW-1:0] packets_down;
    logic [CountW-1:0] mark_octets_all;
    logic [CountW-1:0] mark_octets_up;
    logic [CountW-1:0] mark_octets_down;
    logic [CountW-1:0] mark_packets_all;
    logic [CountW-1:0] mark_packets_up;
    logic [CountW-1:0] mark_packets_down;
    logic [TimeW-1:0]  mark_time;
    logic [TimeW-1:0]  first_time;
    logic [TimeW-1:0]  last_time;
    logic [TimeW-1:0]  period_start;
    logic [SeqW-1:0]   report_count;
  } entry_t;

endpackage

// File: rtl/usage_rule_traffic_metering_top.sv
// ----------------------------------------------------------------------------
// Usage rule traffic metering
// Table of per-rule octet and packet counters with snapshots and usage
// reports carrying deltas, a rounded duration and a time threshold flag.
// ----------------------------------------------------------------------------
// How the block is used:
// A word is taken at a rising clock edge where start_i is high and busy_o is
// low. Each word addresses one usage rule entry and counts a packet, asks for
// a report, takes a snapshot or starts a reporting period. Words whose
// urr_id_i lies beyond the table are dropped without a result.
// Only a report produces a result word. It is shown for exactly one cycle
// with done_o high; the receiver cannot stall and must take it then.
// The entries live in one synchronous memory with a registered read. Count,
// snapshot and start-period words read the entry, then modify it and write
// it back. A report goes on through a prepare state and the divider, which
// turns the elapsed microseconds plus half a second into whole seconds one
// 16-bit digit at a time; busy_o drops in the same cycle that done_o rises,
// so the next word can be taken then. Only one word is in flight, so a
// write-back always lands before the next read of the same entry.
// Reset clears the whole table at once through one valid flag per entry; an
// entry not yet written reads as all zero. There is no clearing pass.
// ----------------------------------------------------------------------------
module usage_rule_traffic_metering_top #(
  parameter int unsigned RULE_ENTRIES = urtm_pkg::RuleEntriesDefault
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  output logic                              busy_o,
  input  logic [urtm_pkg::KindW-1:0]        kind_i,
  input  logic [urtm_pkg::UrrIdW-1:0]       urr_id_i,
  input  logic [urtm_pkg::OctetsW-1:0]      packet_octets_i,
  input  logic                              is_uplink_i,
  input  logic [urtm_pkg::TimeW-1:0]        now_us_i,
  input  logic [urtm_pkg::ThreshW-1:0]      time_threshold_s_i,
  output logic                              done_o,
  output logic [urtm_pkg::SeqW-1:0]         sequence_res_o,
  output logic [urtm_pkg::TimeW-1:0]        period_start_us_o,
  output logic [urtm_pkg::CountW-1:0]       volume_all_o,
  output logic [urtm_pkg::CountW-1:0]       volume_up_o,
  output logic [urtm_pkg::CountW-1:0]       volume_down_o,
  output logic [urtm_pkg::CountW-1:0]       count_all_o,
  output logic [urtm_pkg::CountW-1:0]       count_up_o,
  output logic [urtm_pkg::CountW-1:0]       count_down_o,
  output logic [urtm_pkg::DurW-1:0]         duration_s_o,
  output logic                              threshold_reached_o,
  output logic [urtm_pkg::TimeW-1:0]        first_seen_us_o,
  output logic [urtm_pkg::TimeW-1:0]        last_seen_us_o
);
  import urtm_pkg::*;

  localparam int unsigned IdxW = (RULE_ENTRIES > 1) ? $clog2(RULE_ENTRIES) : 1;

  typedef enum logic [1:0] {
    StIdle,
    StModify,
    StPrep,
    StDiv
  } state_e;

  // Control state.
  state_e            state_q;
  logic              done_q;
  logic              div_start_q;
  logic              thr_hit_q;
  logic              in_range_q;
  logic [RULE_ENTRIES-1:0] vld_q;

  // Accepted word.
  kind_e             kind_q;
  logic [IdxW-1:0]   addr_q;
  logic [OctetsW-1:0] octets_q;
  logic              uplink_q;
  logic [TimeW-1:0]  now_q;
  logic [ThreshW-1:0] thr_q;

  // Table memory and its registered read port.
  entry_t            mem_q [RULE_ENTRIES];
  entry_t            rd_q;
  logic              rd_vld_q;

  // Report datapath registers.
  logic [TimeW-1:0]  diff_q;
  logic              neg_q;
  logic [DvdW-1:0]   dvd_q;
  logic [SeqW-1:0]   seq_q;
  logic [TimeW-1:0]  period_q;
  logic [CountW-1:0] vol_all_q, vol_up_q, vol_down_q;
  logic [CountW-1:0] cnt_all_q, cnt_up_q, cnt_down_q;
  logic [TimeW-1:0]  first_q, last_q;

  logic              accept;
  logic              in_range;
  logic [IdxW-1:0]   addr_in;
  entry_t            ent;
  entry_t            ent_d;
  logic              wr_en;
  logic [TimeW-1:0]  base;
  logic [TimeW:0]    diff_full;
  logic              div_done;
  logic [DvdW-1:0]   quotient;

  assign accept   = start_i && (state_q == StIdle);
  assign in_range = (32'(urr_id_i) < RULE_ENTRIES);
  assign addr_in  = IdxW'(urr_id_i);

  // An entry never written since reset reads as zero.
  assign ent = rd_vld_q ? rd_q : '0;

  // Modify step of the read-modify-write.
  always_comb begin
    ent_d = ent;
    wr_en = 1'b0;
    if (state_q == StModify && in_range_q) begin
      wr_en = 1'b1;
      case (kind_q)
        KindCount: begin
          ent_d.octets_all  = ent.octets_all + CountW'(octets_q);
          ent_d.packets_all = ent.packets_all + CountW'(1);
          if (uplink_q) begin
            ent_d.octets_up  = ent.octets_up + CountW'(octets_q);
            ent_d.packets_up = ent.packets_up + CountW'(1);
          end else begin
            ent_d.octets_down  = ent.octets_down + CountW'(octets_q);
            ent_d.packets_down = ent.packets_down + CountW'(1);
          end
          ent_d.last_time = now_q;
          if (ent.first_time == '0) begin
            ent_d.first_time = now_q;
          end
        end
        KindReport: begin
          ent_d.report_count = ent.report_count + SeqW'(1);
        end
        KindSnapshot: begin
          ent_d.mark_octets_all   = ent.octets_all;
          ent_d.mark_octets_up    = ent.octets_up;
          ent_d.mark_octets_down  = ent.octets_down;
          ent_d.mark_packets_all  = ent.packets_all;
          ent_d.mark_packets_up   = ent.packets_up;
          ent_d.mark_packets_down = ent.packets_down;
          ent_d.mark_time         = now_q;
        end
        KindStart: begin
          ent_d.period_start = now_q;
        end
        default: begin
          wr_en = 1'b0;
        end
      endcase
    end
  end

  // A zero snapshot time means no snapshot, so the period start is the base.
  assign base      = (ent.mark_time != '0) ? ent.mark_time : ent.period_start;
  assign diff_full = {1'b0, now_q} - {1'b0, base};

  // Memory write and registered read.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[addr_q] <= ent_d;
    end
    if (accept) begin
      rd_q <= mem_q[addr_in];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (wr_en) begin
      vld_q[addr_q] <= 1'b1;
    end
  end

  // Sequencer with its registered outputs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      done_q      <= 1'b0;
      div_start_q <= 1'b0;
      thr_hit_q   <= 1'b0;
      in_range_q  <= 1'b0;
      rd_vld_q    <= 1'b0;
    end else begin
      done_q      <= 1'b0;
      div_start_q <= 1'b0;
      case (state_q)
        StIdle: begin
          if (accept) begin
            in_range_q <= in_range;
            rd_vld_q   <= vld_q[addr_in];
            state_q    <= StModify;
          end
        end
        StModify: begin
          if (in_range_q && kind_q == KindReport) begin
            state_q <= StPrep;
          end else begin
            state_q <= StIdle;
          end
        end
        StPrep: begin
          div_start_q <= 1'b1;
          state_q     <= StDiv;
        end
        StDiv: begin
          if (div_done) begin
            thr_hit_q <= (thr_q != '0) && (quotient >= DvdW'(thr_q));
            done_q    <= 1'b1;
            state_q   <= StIdle;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q   <= kind_e'(kind_i);
      addr_q   <= addr_in;
      octets_q <= packet_octets_i;
      uplink_q <= is_uplink_i;
      now_q    <= now_us_i;
      thr_q    <= time_threshold_s_i;
    end
    if (state_q == StModify && in_range_q && kind_q == KindReport) begin
      seq_q      <= ent.report_count;
      period_q   <= ent.period_start;
      vol_all_q  <= ent.octets_all - ent.mark_octets_all;
      vol_up_q   <= ent.octets_up - ent.mark_octets_up;
      vol_down_q <= ent.octets_down - ent.mark_octets_down;
      cnt_all_q  <= ent.packets_all - ent.mark_packets_all;
      cnt_up_q   <= ent.packets_up - ent.mark_packets_up;
      cnt_down_q <= ent.packets_down - ent.mark_packets_down;
      first_q    <= ent.first_time;
      last_q     <= ent.last_time;
      diff_q     <= diff_full[TimeW-1:0];
      neg_q      <= diff_full[TimeW];
    end
    // Add half a second so that the truncating divide rounds to nearest.
    if (state_q == StPrep) begin
      dvd_q <= neg_q ? '0 : (DvdW'(diff_q) + HalfSecUs);
    end
  end

  urtm_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start_q),
    .dividend_i (dvd_q),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  assign busy_o              = (state_q != StIdle);
  assign done_o              = done_q;
  assign sequence_res_o      = seq_q;
  assign period_start_us_o   = period_q;
  assign volume_all_o        = vol_all_q;
  assign volume_up_o         = vol_up_q;
  assign volume_down_o       = vol_down_q;
  assign count_all_o         = cnt_all_q;
  assign count_up_o          = cnt_up_q;
  assign count_down_o        = cnt_down_q;
  assign duration_s_o        = quotient[DurW-1:0];
  assign threshold_reached_o = thr_hit_q;
  assign first_seen_us_o     = first_q;
  assign last_seen_us_o      = last_q;

endmodule

// File: rtl/urtm_div.sv
// ----------------------------------------------------------------------------
// Duration divider
// Turns microseconds into whole seconds: a shift by six, then long division
// by 15625 over four 16-bit digits, each estimated and then folded back.
// ----------------------------------------------------------------------------
module urtm_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [urtm_pkg::DvdW-1:0]     dividend_i,
  output logic                          done_o,
  output logic [urtm_pkg::DvdW-1:0]     quotient_o
);
  import urtm_pkg::*;

  localparam int unsigned Digits = DvdW / DigitW;
  localparam int unsigned CntW   = $clog2(Digits);
  localparam int unsigned NumW   = RcpDivW + DigitW;
  localparam int unsigned ProdW  = NumW + RcpMulW;

  logic              run_q, run_d;
  logic              done_q, done_d;
  logic              fold_q, fold_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [RcpDivW-1:0] rem_q, rem_d;
  logic [DvdW-1:0]   dvd_q, dvd_d;
  logic [DigitW-1:0] dig_q, dig_d;
  logic [NumW-1:0]   num;
  logic [ProdW-1:0]  prod;
  logic [NumW-1:0]   back;

  // The dividend shifts out at the top one digit per step while quotient
  // digits enter at the bottom. Each step first estimates the digit, then
  // folds it back into the remainder.
  always_comb begin
    num    = {rem_q, dvd_q[DvdW-1 -: DigitW]};
    prod   = ProdW'(num) * ProdW'(RcpMul);
    back   = NumW'(dig_q) * NumW'(RcpDiv);
    run_d  = run_q;
    done_d = 1'b0;
    fold_d = fold_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dvd_d  = dvd_q;
    dig_d  = dig_q;
    if (start_i) begin
      run_d  = 1'b1;
      fold_d = 1'b0;
      cnt_d  = '0;
      rem_d  = '0;
      dvd_d  = dividend_i >> PreShift;
    end else if (run_q) begin
      if (!fold_q) begin
        dig_d  = DigitW'(prod >> RcpShift);
        fold_d = 1'b1;
      end else begin
        rem_d  = RcpDivW'(num - back);
        dvd_d  = {dvd_q[DvdW-DigitW-1:0], dig_q};
        fold_d = 1'b0;
        cnt_d  = cnt_q + CntW'(1);
        if (cnt_q == CntW'(Digits - 1)) begin
          run_d  = 1'b0;
          done_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      fold_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      fold_q <= fold_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvd_q <= dvd_d;
    dig_q <= dig_d;
  end

  assign done_o     = done_q;
  assign quotient_o = dvd_q;

endmodule
